// File: hdl/atb_pkg.sv
// output field width constants for the alias table builder
`timescale 1ns / 1ps
`default_nettype none
package atb_pkg;
    localparam int unsigned OUT_IDX_W = 6;
    localparam int unsigned OUT_PROB_W = 17;
endpackage
`default_nettype wire

// File: hdl/alias_table_builder_core.sv
// alias table builder top level: load, scale, pair, emit
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   input channel: i_weight / i_last_weight with i_valid, o_stall. weights are
//   taken one per cycle while loading; negatives count as zero. beats beyond
//   MAX_ENTRIES are dropped but a last beat still ends the set.
//   after the last beat the block stalls input until the last entry is emitted:
//   a scaling sweep (one memory read then write per entry), pairing (check,
//   small read, large read, a serial divide for each small entry, then write
//   back), then emission of the entries while the receiver takes them.
//   output channel: o_entry_index, o_accept_prob, o_alias_index, o_last_entry
//   with o_valid, i_stall. a stalled beat holds; emission pauses on stall.
//   the time per set after the last beat is set by the single divider and
//   the single-port scaled memory.
//   reset (synchronous, active low) returns to loading with an empty set.
//   a zero total or leftover entries give probability 1.0 and a self alias.
module alias_table_builder_core #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned WEIGHT_BITS = 32,
    parameter int unsigned PROB_FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [WEIGHT_BITS-1:0]       i_weight,
    input  wire logic                                i_last_weight,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [$clog2(MAX_ENTRIES)-1:0]           o_entry_index,
    output logic [PROB_FRAC_BITS:0]                  o_accept_prob,
    output logic [$clog2(MAX_ENTRIES)-1:0]           o_alias_index,
    output logic                                     o_last_entry
);
    localparam int unsigned IW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = IW + 1;
    localparam int unsigned TW = WEIGHT_BITS + IW;
    localparam int unsigned SW = TW + CW + 1;
    localparam int unsigned PW = PROB_FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_LOAD, S_SC_RD, S_SC_WR, S_PR_CHK, S_PR_RD_S, S_PR_RD_L, S_PR_DIV,
        S_PR_WR, S_EM_RD, S_EM_OUT
    } t_state;

    t_state r_state;

    logic [SW-1:0] scaled_mem [MAX_ENTRIES];
    logic [IW-1:0] small_mem  [MAX_ENTRIES];
    logic [IW-1:0] large_mem  [MAX_ENTRIES];
    logic [PW-1:0] prob_mem   [MAX_ENTRIES];
    logic [IW-1:0] alias_mem  [MAX_ENTRIES];

    logic [TW-1:0] r_total;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_small_cnt, r_large_cnt;
    logic [CW-1:0] r_idx;
    logic [IW-1:0] r_s, r_l;
    logic [SW-1:0] r_sv, r_rd;
    logic [IW-1:0] r_small_rd, r_large_rd;
    logic [PW-1:0] r_prob_rd;
    logic [IW-1:0] r_alias_rd;
    logic          r_div_start;
    logic          r_out_valid;
    logic [IW-1:0] r_out_idx, r_out_alias;
    logic [PW-1:0] r_out_prob;
    logic          r_out_last;

    logic          div_done;
    logic [PW-1:0] div_quot;

    logic [WEIGHT_BITS-1:0] w_raw;
    logic [WEIGHT_BITS-1:0] w_clamp;
    logic                   in_fire;
    logic [SW-1:0]          n_scaled;
    logic [SW-1:0]          n_lval;
    logic [SW-1:0]          total_ext;
    logic [IW-1:0]          scaled_raddr;

    assign w_raw   = $unsigned(i_weight);
    assign w_clamp = w_raw[WEIGHT_BITS-1] ? '0 : w_raw;
    assign o_stall = (r_state != S_LOAD);
    assign in_fire = i_valid && !o_stall;
    assign total_ext = SW'(r_total);
    assign n_scaled  = SW'(r_rd[TW-1:0] * r_count);
    assign n_lval    = r_rd + r_sv - total_ext;

    // small index goes straight from the stack read; large index held through the step
    always_comb begin
        case (r_state)
            S_PR_RD_S:                    scaled_raddr = r_small_rd;
            S_PR_RD_L, S_PR_DIV, S_PR_WR: scaled_raddr = r_l;
            default:                      scaled_raddr = r_idx[IW-1:0];
        endcase
    end

    atb_divider #(.VAL_W(SW), .FRAC_BITS(PROB_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_sv),
        .i_den   (total_ext),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // synchronous memory reads
    always_ff @(posedge i_clk) begin
        r_rd       <= scaled_mem[scaled_raddr];
        r_small_rd <= small_mem[IW'(r_small_cnt - 1'b1)];
        r_large_rd <= large_mem[IW'(r_large_cnt - 1'b1)];
        r_prob_rd  <= prob_mem[r_idx[IW-1:0]];
        r_alias_rd <= alias_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_total     <= '0;
            r_count     <= '0;
            r_small_cnt <= '0;
            r_large_cnt <= '0;
            r_idx       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (r_count < CW'(MAX_ENTRIES)) begin
                            scaled_mem[r_count[IW-1:0]] <= SW'(w_clamp);
                            prob_mem[r_count[IW-1:0]]   <= PW'(1) << PROB_FRAC_BITS;
                            alias_mem[r_count[IW-1:0]]  <= r_count[IW-1:0];
                            r_total <= r_total + TW'(w_clamp);
                            r_count <= r_count + 1'b1;
                        end
                        if (i_last_weight) begin
                            r_idx       <= '0;
                            r_small_cnt <= '0;
                            r_large_cnt <= '0;
                            r_state     <= S_SC_RD;
                        end
                    end
                end
                S_SC_RD: begin
                    if (r_total == '0 || r_idx == r_count) begin
                        r_idx   <= '0;
                        r_state <= (r_total == '0) ? S_EM_RD : S_PR_CHK;
                    end else begin
                        r_state <= S_SC_WR;
                    end
                end
                S_SC_WR: begin
                    scaled_mem[r_idx[IW-1:0]] <= n_scaled;
                    if (n_scaled < total_ext) begin
                        small_mem[r_small_cnt[IW-1:0]] <= r_idx[IW-1:0];
                        r_small_cnt <= r_small_cnt + 1'b1;
                    end else begin
                        large_mem[r_large_cnt[IW-1:0]] <= r_idx[IW-1:0];
                        r_large_cnt <= r_large_cnt + 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SC_RD;
                end
                S_PR_CHK: begin
                    // stack top reads are issued this cycle from the current counts and used in S_PR_RD_S
                    if (r_small_cnt == '0 || r_large_cnt == '0) begin
                        r_idx   <= '0;
                        r_state <= S_EM_RD;
                    end else begin
                        r_state <= S_PR_RD_S;
                    end
                end
                S_PR_RD_S: begin
                    r_s <= r_small_rd;
                    r_l <= r_large_rd;
                    r_small_cnt <= r_small_cnt - 1'b1;
                    r_state <= S_PR_RD_L;
                end
                S_PR_RD_L: begin
                    r_sv        <= r_rd;
                    r_div_start <= 1'b1;
                    r_state     <= S_PR_DIV;
                end
                S_PR_DIV: begin
                    if (div_done) begin
                        prob_mem[r_s]  <= div_quot;
                        alias_mem[r_s] <= r_l;
                        r_state        <= S_PR_WR;
                    end
                end
                S_PR_WR: begin
                    scaled_mem[r_l] <= n_lval;
                    if (n_lval < total_ext) begin
                        r_large_cnt <= r_large_cnt - 1'b1;
                        small_mem[r_small_cnt[IW-1:0]] <= r_l;
                        r_small_cnt <= r_small_cnt + 1'b1;
                    end
                    r_state <= S_PR_CHK;
                end
                S_EM_RD: begin
                    if (!r_out_valid || !i_stall) begin
                        r_state <= S_EM_OUT;
                    end
                end
                S_EM_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out_idx   <= r_idx[IW-1:0];
                    r_out_prob  <= r_prob_rd;
                    r_out_alias <= r_alias_rd;
                    r_out_last  <= (r_idx + 1'b1 == r_count);
                    if (r_idx + 1'b1 == r_count) begin
                        r_count <= '0;
                        r_total <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_EM_RD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_entry_index = r_out_idx;
    assign o_accept_prob = r_out_prob;
    assign o_alias_index = r_out_alias;
    assign o_last_entry  = r_out_last;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> o_stall)
        else $error("input taken while building");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count overflow");
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_small_cnt + r_large_cnt) <= CW'(MAX_ENTRIES))
        else $error("stack overflow");
`endif
endmodule
`default_nettype wire

// File: hdl/atb_divider.sv
// restoring divider: floor(a * 2^F / t), saturated at 2^F, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module atb_divider #(
    parameter int unsigned VAL_W = 44,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [VAL_W-1:0]     i_num,
    input  wire logic [VAL_W-1:0]     i_den,
    output logic                      o_done,
    output logic [FRAC_BITS:0]        o_quot
);
    localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

    logic [VAL_W:0]       r_rem;
    logic [VAL_W-1:0]     r_den;
    logic [FRAC_BITS:0]   r_quot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [VAL_W:0]       n_shift;

    assign n_shift = {r_rem[VAL_W-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den  <= i_den;
                r_rem  <= {1'b0, i_num};
                r_quot <= '0;
                r_cnt  <= CNT_W'(FRAC_BITS);
                if (i_num >= i_den) begin
                    r_quot <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem  <= n_shift - {1'b0, r_den};
                    r_quot <= {r_quot[FRAC_BITS-1:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_quot <= {r_quot[FRAC_BITS-1:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// File: dv/alias_table_builder_core_tb.sv
// testbench for the alias table builder: directed, overflow and random weight sets
`timescale 1ns / 1ps
module alias_table_builder_core_tb;
    import atb_pkg::*;

    localparam int unsigned MAX_N = 64;
    localparam int unsigned FRAC = 16;
    localparam longint unsigned CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]  index;
        logic [OUT_PROB_W-1:0] prob;
        logic [OUT_IDX_W-1:0]  alias_idx;
        logic                  last;
    } t_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_weight = '0;
    logic i_last_weight = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [OUT_IDX_W-1:0] o_entry_index;
    logic [OUT_PROB_W-1:0] o_accept_prob;
    logic [OUT_IDX_W-1:0] o_alias_index;
    logic o_last_entry;

    alias_table_builder_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_weight(i_weight), .i_last_weight(i_last_weight), .o_valid(o_valid),
        .i_stall(i_stall), .o_entry_index(o_entry_index),
        .o_accept_prob(o_accept_prob), .o_alias_index(o_alias_index),
        .o_last_entry(o_last_entry)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [37:0] scaled [MAX_N];
    logic [36:0] total;
    int unsigned loaded;
    t_entry table_q[$];
    int errors = 0;
    longint unsigned cycles = 0;
    int stall_left = 0;

    task automatic report(input string what, input t_entry got, input t_entry want);
        errors++;
        $display("mismatch %s: got idx %0d p %0d a %0d l %0d, want idx %0d p %0d a %0d l %0d",
                 what, got.index, got.prob, got.alias_idx, got.last,
                 want.index, want.prob, want.alias_idx, want.last);
    endtask

    function automatic logic [16:0] ratio(input logic [37:0] a, input logic [36:0] t);
        logic [38:0] r;
        logic [16:0] q;
        if (a >= t) return 17'd1 << FRAC;
        q = '0;
        r = a;
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= t) begin
                r = r - t;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    task automatic build_and_queue();
        logic [16:0] prob [MAX_N];
        logic [5:0] ali [MAX_N];
        int unsigned sm [MAX_N];
        int unsigned lg [MAX_N];
        int unsigned sc, lc;
        int unsigned s, l, n;
        t_entry e;
        n = loaded;
        sc = 0;
        lc = 0;
        for (int i = 0; i < n; i++) begin
            prob[i] = 17'd1 << FRAC;
            ali[i] = i[5:0];
        end
        if (total != 0) begin
            for (int i = 0; i < n; i++) begin
                scaled[i] = scaled[i] * n;
                if (scaled[i] < total) begin
                    sm[sc] = i;
                    sc++;
                end else begin
                    lg[lc] = i;
                    lc++;
                end
            end
            while (sc > 0 && lc > 0) begin
                sc--;
                s = sm[sc];
                l = lg[lc-1];
                prob[s] = ratio(scaled[s], total);
                ali[s] = l[5:0];
                scaled[l] = (scaled[l] + scaled[s]) - total;
                if (scaled[l] < total) begin
                    lc--;
                    sm[sc] = l;
                    sc++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            e.index = i[5:0];
            e.prob = prob[i];
            e.alias_idx = ali[i];
            e.last = (i + 1 == n);
            table_q.insert(table_q.size(), e);
        end
        loaded = 0;
        total = '0;
    endtask

    task automatic send_weight(input logic signed [31:0] w, input logic last);
        int gap;
        logic [31:0] cw;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_weight <= w;
        i_last_weight <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        cw = (w < 0) ? 32'd0 : w;
        if (loaded < MAX_N) begin
            scaled[loaded] = {6'd0, cw};
            total = total + cw;
            loaded++;
        end
        if (last) build_and_queue();
    endtask

    // output side: per-beat wait and compare
    always @(posedge i_clk) begin
        t_entry got, want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_entry_index, o_accept_prob, o_alias_index, o_last_entry};
                if (table_q.size() == 0) report("unexpected beat", got, got);
                else begin
                    want = table_q.pop_front();
                    if (got != want) report("entry", got, want);
                end
                stall_left = $urandom_range(0, 5);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (table_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_weight(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1000);
            2: return 32'sh7fffffff - $urandom_range(0, 3);
            default: return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
        endcase
    endfunction

    task automatic send_set(input int n, input int mode);
        for (int i = 0; i < n; i++) send_weight(rand_weight(mode), i == n - 1);
    endtask

    task automatic test_directed();
        send_weight(32'sh7fffffff, 1'b1);                 // single entry
        send_weight(-32'sd1, 1'b0); send_weight(0, 1'b1); // zero total
        send_weight(32'sh80000000, 1'b0); send_weight(32'sh7fffffff, 1'b0);
        send_weight(1, 1'b0); send_weight(32'sh7fffffff, 1'b1);
        send_weight(5, 1'b0); send_weight(5, 1'b0); send_weight(5, 1'b1); // uniform
        send_weight(1, 1'b0); send_weight(0, 1'b0); send_weight(3, 1'b1);
        wait_drained();
    endtask

    task automatic test_overflow();
        // more weights than entries: the extra ones are dropped
        for (int i = 0; i < MAX_N + 3; i++) send_weight($urandom_range(0, 50), i == MAX_N + 2);
        for (int i = 0; i < MAX_N; i++) send_weight(32'sh7fffffff, i == MAX_N - 1);
        wait_drained();
    endtask

    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 300) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
            send_set(n, $urandom_range(0, 3));
            sent += n;
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        loaded = 0;
        total = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_random();
        repeat (2000) @(posedge i_clk);
        if (errors == 0 && table_q.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
hdl/atb_pkg.sv
hdl/atb_divider.sv
hdl/alias_table_builder_core.sv
dv/alias_table_builder_core_tb.sv
